>>> hw/rtl/dqrp_pkg.sv
// dqrp_pkg: shared types and constants of the delivery queue retry policy
// no dependencies; used by the interfaces, the controller, the datapath and the top level
package dqrp_pkg;

   localparam int BODY_W   = 12;
   localparam int STATUS_W = 10;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 12;
   localparam int IDX_W    = 32;
   localparam int SLOT_OUT_W    = 4;
   localparam int PENDING_OUT_W = 5;
   localparam int BR_CNT_W   = 4;
   localparam int CONF_CNT_W = 6;
   localparam int AUTH_CNT_W = 4;

   // response status codes the policy looks at
   localparam logic [STATUS_W-1:0] ST_BAD_REQUEST = 10'd400;
   localparam logic [STATUS_W-1:0] ST_UNAUTH      = 10'd401;
   localparam logic [STATUS_W-1:0] ST_TIMEOUT     = 10'd408;
   localparam logic [STATUS_W-1:0] ST_CONFLICT    = 10'd409;
   localparam logic [STATUS_W-1:0] ST_TOO_MANY    = 10'd429;
   localparam logic [STATUS_W-1:0] ST_SERVER      = 10'd500;

   // register reset values
   localparam logic [BODY_W-1:0]     BODY_LIMIT_RST  = 12'd896;
   localparam logic [BR_CNT_W-1:0]   BR_TRIES_RST    = 4'd3;
   localparam logic [CONF_CNT_W-1:0] CONF_LIMIT_RST  = 6'd20;
   localparam logic [AUTH_CNT_W-1:0] AUTH_LIMIT_RST  = 4'd3;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_BODY_LIMIT = 2'd0,
      CSR_BR_TRIES   = 2'd1,
      CSR_CONF_LIMIT = 2'd2,
      CSR_AUTH_LIMIT = 2'd3
   } dqrp_csr_type;

   typedef enum logic [1:0] {
      CMD_PUSH    = 2'd0,
      CMD_OUTCOME = 2'd1,
      CMD_SKIP    = 2'd2
   } dqrp_op_type;

   typedef enum logic [1:0] {
      RSN_NONE    = 2'd0,
      RSN_FULL    = 2'd1,
      RSN_TOO_LONG = 2'd2
   } dqrp_reason_type;

   typedef enum logic [1:0] {
      ACT_NONE    = 2'd0,
      ACT_RETRY   = 2'd1,
      ACT_DISCARD = 2'd2
   } dqrp_action_type;

   typedef enum logic {
      CTL_IDLE = 1'b0,
      CTL_EXEC = 1'b1
   } dqrp_state_type;

   // controller to datapath commands
   typedef struct packed {
      logic capture;   // latch the request fields
      logic execute;   // apply the policy and load the response
   } dqrp_cmd_type;

endpackage

>>> hw/rtl/dqrp_if.sv
// dqrp_if: valid/ready channel interfaces for request, response and register writes
// depends on dqrp_pkg for field widths
interface dqrp_req_if import dqrp_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [1:0]          command;
   logic [BODY_W-1:0]   body_length;
   logic                delivered;
   logic [STATUS_W-1:0] status_code;

   modport source (output valid, command, body_length, delivered, status_code, input ready);
   modport sink   (input valid, command, body_length, delivered, status_code, output ready);
endinterface

interface dqrp_rsp_if import dqrp_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic                     accepted;
   logic [1:0]               reason;
   logic [SLOT_OUT_W-1:0]    slot;
   logic [1:0]               action;
   logic [PENDING_OUT_W-1:0] pending;
   logic                     conflict_stuck;
   logic                     credentials_bad;
   logic                     notify;

   modport source (output valid, accepted, reason, slot, action, pending, conflict_stuck,
                   credentials_bad, notify, input ready);
   modport sink   (input valid, accepted, reason, slot, action, pending, conflict_stuck,
                   credentials_bad, notify, output ready);
endinterface

interface dqrp_csr_if import dqrp_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

>>> hw/rtl/dqrp_ctrl.sv
// dqrp_ctrl: request sequencing state machine and response valid register
// depends on dqrp_pkg for the state and command types
module dqrp_ctrl import dqrp_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output dqrp_cmd_type cmd
);

   dqrp_state_type state_ff, state_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic           req_take;

   // a new request only when the response slot is free by the next edge
   assign req_ready = (state_ff == CTL_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign req_take  = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         CTL_IDLE: begin
            if (req_take) begin
               state_in = CTL_EXEC;
            end
         end
         CTL_EXEC: begin
            state_in = CTL_IDLE;
         end
         default: begin
            state_in = CTL_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd.capture  = req_take;
      cmd.execute  = (state_ff == CTL_EXEC);
      rsp_valid_in = rsp_valid_ff;
      if (state_ff == CTL_EXEC) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= CTL_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   a_exec_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      (state_ff == CTL_EXEC) |=> rsp_valid_ff)
      else $error("execute step did not raise a response");

   a_no_take_while_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff == CTL_EXEC) |-> !req_ready)
      else $error("request taken while one is in execution");

   a_rsp_not_overwritten: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |-> !req_ready)
      else $error("request taken while a stalled response is held");

endmodule

>>> hw/rtl/dqrp_dp.sv
// dqrp_dp: queue indices, retry trackers, policy registers and response register
// depends on dqrp_pkg; driven by commands from dqrp_ctrl
module dqrp_dp import dqrp_pkg::*; #(
   parameter int CAPACITY = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  dqrp_cmd_type             cmd,
   input  logic [1:0]               req_command,
   input  logic [BODY_W-1:0]        req_body_length,
   input  logic                     req_delivered,
   input  logic [STATUS_W-1:0]      req_status_code,
   input  logic                     csr_we,
   input  logic [CSR_IDX_W-1:0]     csr_index,
   input  logic [CSR_DATA_W-1:0]    csr_data,
   output logic                     rsp_accepted,
   output logic [1:0]               rsp_reason,
   output logic [SLOT_OUT_W-1:0]    rsp_slot,
   output logic [1:0]               rsp_action,
   output logic [PENDING_OUT_W-1:0] rsp_pending,
   output logic                     rsp_conflict_stuck,
   output logic                     rsp_credentials_bad,
   output logic                     rsp_notify
);

   localparam int SLOT_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(CAPACITY - 1);
   localparam logic [IDX_W-1:0]  CAP_IDX   = IDX_W'(CAPACITY);
   localparam logic [CONF_CNT_W-1:0] CONF_MAX = '1;
   localparam logic [BR_CNT_W-1:0]   BR_MAX   = '1;
   localparam logic [AUTH_CNT_W-1:0] AUTH_MAX = '1;

   // policy registers
   logic [BODY_W-1:0]     body_limit_ff;
   logic [BR_CNT_W-1:0]   br_tries_ff;
   logic [CONF_CNT_W-1:0] conf_limit_ff;
   logic [AUTH_CNT_W-1:0] auth_limit_ff;

   // captured request
   logic [1:0]          op_ff;
   logic [BODY_W-1:0]   len_ff;
   logic                dlv_ff;
   logic [STATUS_W-1:0] status_ff;

   // queue and tracker state
   logic [IDX_W-1:0]      head_ff, head_in, tail_ff, tail_in;
   logic [SLOT_W-1:0]     head_slot_ff, head_slot_in, tail_slot_ff, tail_slot_in;
   logic [IDX_W-1:0]      br_head_ff, br_head_in, conf_head_ff, conf_head_in;
   logic                  br_valid_ff, br_valid_in, conf_valid_ff, conf_valid_in;
   logic [BR_CNT_W-1:0]   br_cnt_ff, br_cnt_in;
   logic [CONF_CNT_W-1:0] conf_cnt_ff, conf_cnt_in;
   logic [AUTH_CNT_W-1:0] auth_cnt_ff, auth_cnt_in;
   logic                  conf_flag_ff, conf_flag_in, auth_flag_ff, auth_flag_in;

   // response register
   logic                     res_acc_ff, res_acc_in;
   logic [1:0]               res_reason_ff, res_reason_in;
   logic [SLOT_OUT_W-1:0]    res_slot_ff, res_slot_in;
   logic [1:0]               res_action_ff, res_action_in;
   logic [PENDING_OUT_W-1:0] res_pending_ff;
   logic                     res_notify_ff, res_notify_in;

   logic [IDX_W-1:0] queued;
   logic [IDX_W-1:0] pending_in;
   logic [IDX_W-1:0] slot_wide;
   logic [SLOT_W-1:0] slot_sel;
   logic             drop;

   assign queued     = tail_ff - head_ff;
   assign pending_in = tail_in - head_in;

   always_comb begin
      head_in      = head_ff;
      tail_in      = tail_ff;
      tail_slot_in = tail_slot_ff;
      br_head_in   = br_head_ff;
      br_valid_in  = br_valid_ff;
      br_cnt_in    = br_cnt_ff;
      conf_head_in = conf_head_ff;
      conf_valid_in = conf_valid_ff;
      conf_cnt_in  = conf_cnt_ff;
      auth_cnt_in  = auth_cnt_ff;
      conf_flag_in = conf_flag_ff;
      auth_flag_in = auth_flag_ff;
      res_acc_in    = 1'b0;
      res_reason_in = RSN_NONE;
      res_action_in = ACT_NONE;
      res_notify_in = 1'b0;
      drop          = 1'b0;
      slot_sel      = head_slot_ff;

      case (op_ff)
         CMD_PUSH: begin
            if (len_ff == '0) begin
               res_reason_in = RSN_NONE;
            end else if (len_ff >= body_limit_ff) begin
               res_reason_in = RSN_TOO_LONG;
            end else if (queued >= CAP_IDX) begin
               res_reason_in = RSN_FULL;
            end else begin
               slot_sel      = tail_slot_ff;
               tail_in       = tail_ff + 1'b1;
               // 32-bit wrap restarts the slot count
               tail_slot_in  = (tail_slot_ff == SLOT_LAST || tail_ff == '1) ?
                               '0 : tail_slot_ff + 1'b1;
               res_acc_in    = 1'b1;
               res_notify_in = 1'b1;
            end
         end
         CMD_OUTCOME: begin
            if (queued != '0) begin
               if (dlv_ff) begin
                  br_valid_in   = 1'b0;
                  conf_valid_in = 1'b0;
                  conf_cnt_in   = '0;
                  auth_cnt_in   = '0;
                  conf_flag_in  = 1'b0;
                  auth_flag_in  = 1'b0;
                  drop          = 1'b1;
                  res_action_in = ACT_DISCARD;
                  res_notify_in = 1'b1;
               end else if (status_ff == ST_UNAUTH) begin
                  if (auth_cnt_ff != AUTH_MAX) begin
                     auth_cnt_in = auth_cnt_ff + 1'b1;
                  end
                  if (auth_cnt_in >= auth_limit_ff && !auth_flag_ff) begin
                     auth_flag_in  = 1'b1;
                     res_notify_in = 1'b1;
                  end
                  res_action_in = ACT_RETRY;
               end else begin
                  auth_cnt_in  = '0;
                  auth_flag_in = 1'b0;
                  if (status_ff == ST_CONFLICT) begin
                     if (conf_valid_ff && conf_head_ff == head_ff) begin
                        if (conf_cnt_ff != CONF_MAX) begin
                           conf_cnt_in = conf_cnt_ff + 1'b1;
                        end
                     end else begin
                        // a new head starts a fresh conflict run
                        conf_valid_in = 1'b1;
                        conf_head_in  = head_ff;
                        conf_cnt_in   = CONF_CNT_W'(1);
                        conf_flag_in  = 1'b0;
                     end
                     if (conf_cnt_in >= conf_limit_ff && !conf_flag_in) begin
                        conf_flag_in  = 1'b1;
                        res_notify_in = 1'b1;
                     end
                     res_action_in = ACT_RETRY;
                  end else if (status_ff == ST_BAD_REQUEST) begin
                     if (br_valid_ff && br_head_ff == head_ff) begin
                        if (br_cnt_ff != BR_MAX) begin
                           br_cnt_in = br_cnt_ff + 1'b1;
                        end
                     end else begin
                        br_valid_in = 1'b1;
                        br_head_in  = head_ff;
                        br_cnt_in   = BR_CNT_W'(1);
                     end
                     if (br_cnt_in < br_tries_ff) begin
                        res_action_in = ACT_RETRY;
                     end else begin
                        drop          = 1'b1;
                        br_valid_in   = 1'b0;
                        res_action_in = ACT_DISCARD;
                        res_notify_in = 1'b1;
                     end
                  end else if (status_ff >= ST_BAD_REQUEST && status_ff < ST_SERVER &&
                               status_ff != ST_TIMEOUT && status_ff != ST_TOO_MANY) begin
                     drop          = 1'b1;
                     res_action_in = ACT_DISCARD;
                     res_notify_in = 1'b1;
                  end else begin
                     res_action_in = ACT_RETRY;
                  end
               end
            end
         end
         CMD_SKIP: begin
            if (queued != '0) begin
               drop          = 1'b1;
               res_action_in = ACT_DISCARD;
               res_notify_in = 1'b1;
            end
         end
         default: begin
            res_action_in = ACT_NONE;
         end
      endcase

      head_slot_in = head_slot_ff;
      if (drop) begin
         head_in      = head_ff + 1'b1;
         head_slot_in = (head_slot_ff == SLOT_LAST || head_ff == '1) ?
                        '0 : head_slot_ff + 1'b1;
         slot_sel     = head_slot_in;
      end
      slot_wide   = IDX_W'(slot_sel);
      res_slot_in = slot_wide[SLOT_OUT_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         body_limit_ff <= BODY_LIMIT_RST;
         br_tries_ff   <= BR_TRIES_RST;
         conf_limit_ff <= CONF_LIMIT_RST;
         auth_limit_ff <= AUTH_LIMIT_RST;
      end else if (csr_we) begin
         case (csr_index)
            CSR_BODY_LIMIT: body_limit_ff <= csr_data[BODY_W-1:0];
            CSR_BR_TRIES:   br_tries_ff   <= csr_data[BR_CNT_W-1:0];
            CSR_CONF_LIMIT: conf_limit_ff <= csr_data[CONF_CNT_W-1:0];
            CSR_AUTH_LIMIT: auth_limit_ff <= csr_data[AUTH_CNT_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff       <= '0;
         tail_ff       <= '0;
         head_slot_ff  <= '0;
         tail_slot_ff  <= '0;
         br_head_ff    <= '0;
         br_valid_ff   <= 1'b0;
         br_cnt_ff     <= '0;
         conf_head_ff  <= '0;
         conf_valid_ff <= 1'b0;
         conf_cnt_ff   <= '0;
         auth_cnt_ff   <= '0;
         conf_flag_ff  <= 1'b0;
         auth_flag_ff  <= 1'b0;
      end else if (cmd.execute) begin
         head_ff       <= head_in;
         tail_ff       <= tail_in;
         head_slot_ff  <= head_slot_in;
         tail_slot_ff  <= tail_slot_in;
         br_head_ff    <= br_head_in;
         br_valid_ff   <= br_valid_in;
         br_cnt_ff     <= br_cnt_in;
         conf_head_ff  <= conf_head_in;
         conf_valid_ff <= conf_valid_in;
         conf_cnt_ff   <= conf_cnt_in;
         auth_cnt_ff   <= auth_cnt_in;
         conf_flag_ff  <= conf_flag_in;
         auth_flag_ff  <= auth_flag_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff     <= req_command;
         len_ff    <= req_body_length;
         dlv_ff    <= req_delivered;
         status_ff <= req_status_code;
      end
      if (cmd.execute) begin
         res_acc_ff     <= res_acc_in;
         res_reason_ff  <= res_reason_in;
         res_slot_ff    <= res_slot_in;
         res_action_ff  <= res_action_in;
         res_pending_ff <= pending_in[PENDING_OUT_W-1:0];
         res_notify_ff  <= res_notify_in;
      end
   end

   assign rsp_accepted        = res_acc_ff;
   assign rsp_reason          = res_reason_ff;
   assign rsp_slot            = res_slot_ff;
   assign rsp_action          = res_action_ff;
   assign rsp_pending         = res_pending_ff;
   assign rsp_conflict_stuck  = conf_flag_ff;
   assign rsp_credentials_bad = auth_flag_ff;
   assign rsp_notify          = res_notify_ff;

   a_occupancy: assert property (@(posedge clock) disable iff (reset)
      queued <= CAP_IDX)
      else $error("queue occupancy above capacity");

   a_push_excludes_action: assert property (@(posedge clock) disable iff (reset)
      (cmd.execute && res_acc_in) |-> (res_action_in == ACT_NONE && res_notify_in))
      else $error("accepted push carries a head action");

   a_discard_moves_head: assert property (@(posedge clock) disable iff (reset)
      (cmd.execute && res_action_in == ACT_DISCARD) |=> (head_ff == $past(head_ff) + 1'b1))
      else $error("discard did not advance the head");

endmodule

>>> hw/rtl/delivery_queue_retry_policy.sv
// delivery_queue_retry_policy: top level of the outbound queue and its retry policy
// depends on dqrp_pkg, dqrp_if, dqrp_ctrl and dqrp_dp
//
//   channel  | direction | payload
//   ---------+-----------+-------------------------------------------------------
//   req_ch   | in        | command, body_length, delivered, status_code
//   rsp_ch   | out       | accepted, reason, slot, action, pending, conflict_stuck,
//            |           | credentials_bad, notify
//   csr_ch   | in        | index, data (register write, always ready)
//
// each request is handled in two steps: capture latches it, execute applies the
// policy and loads the response register; no request is taken during execute
// reset clears queue indices, trackers and flags; policy registers get reset values
// a stalled response holds; the next request is taken in the cycle it leaves
module delivery_queue_retry_policy import dqrp_pkg::*; #(
   parameter int CAPACITY = 16
) (
   input  logic       clock,
   input  logic       reset,
   dqrp_req_if.sink   req_ch,
   dqrp_rsp_if.source rsp_ch,
   dqrp_csr_if.sink   csr_ch
);

   dqrp_cmd_type cmd;

   assign csr_ch.ready = 1'b1;

   dqrp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .cmd       (cmd)
   );

   dqrp_dp #(
      .CAPACITY (CAPACITY)
   ) u_dp (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .req_command         (req_ch.command),
      .req_body_length     (req_ch.body_length),
      .req_delivered       (req_ch.delivered),
      .req_status_code     (req_ch.status_code),
      .csr_we              (csr_ch.valid && csr_ch.ready),
      .csr_index           (csr_ch.index),
      .csr_data            (csr_ch.data),
      .rsp_accepted        (rsp_ch.accepted),
      .rsp_reason          (rsp_ch.reason),
      .rsp_slot            (rsp_ch.slot),
      .rsp_action          (rsp_ch.action),
      .rsp_pending         (rsp_ch.pending),
      .rsp_conflict_stuck  (rsp_ch.conflict_stuck),
      .rsp_credentials_bad (rsp_ch.credentials_bad),
      .rsp_notify          (rsp_ch.notify)
   );

endmodule
